[sv/spq_pkg.sv]
// Shared types, constants and helpers for the sorted priority queue.
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int KEY_W       = 16;
   localparam int ENTRY_CNT_W = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 80;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_UPDATE = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] exec;
      logic [7:0]  id;
   } entry_type;

   typedef struct packed {
      logic                   overflow;
      logic [ENTRY_CNT_W-1:0] entry_count;
      logic                   queue_empty;
      logic [7:0]             front_prio;
      logic [15:0]            front_exec;
      logic [7:0]             front_id;
      logic                   found;
      logic [7:0]             removed_prio;
      logic [15:0]            removed_exec;
      logic [7:0]             removed_id;
      logic                   removed_valid;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   typedef struct packed {
      logic start;
      logic walk;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic out_free;
   } status_type;

   function automatic logic [KEY_W-1:0] key_of(input entry_type e, input logic by_prio);
      logic [KEY_W-1:0] k;
      k = by_prio ? {8'd0, e.prio} : e.exec;
      return k;
   endfunction

endpackage

[sv/spq_ctrl.sv]
// Sequencer for the sorted priority queue: accept, walk the store, finish.
module spq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output spq_pkg::cmd_type    cmd,
   input  spq_pkg::status_type status
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_WALK   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.start = 1'b1;
               state_in  = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/spq_datapath.sv]
// Entry store, walk pointers, carry register and result register.
module spq_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  spq_pkg::cmd_type                     cmd,
   output spq_pkg::status_type                  status,
   input  logic                                 csr_wen,
   input  logic                                 csr_wdata,
   input  logic [spq_pkg::REQ_TUSER_W-1:0]      req_tuser,
   input  logic [spq_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_valid,
   output spq_pkg::result_type                  rsp_result
);

   spq_pkg::entry_type mem [spq_pkg::QUEUE_DEPTH];

   spq_pkg::mode_type   mode_ff, mode_in;
   spq_pkg::entry_type  new_ff, new_in;
   spq_pkg::entry_type  carry_ff, carry_in;
   spq_pkg::entry_type  removed_ff, removed_in;
   spq_pkg::entry_type  front_ff, front_in;
   spq_pkg::entry_type  rd_data_ff;
   spq_pkg::result_type rsp_ff, rsp_in;
   logic placing_ff, placing_in;
   logic found_ff, found_in;
   logic stop_ff, stop_in;
   logic ovf_ff, ovf_in;
   logic removed_valid_ff, removed_valid_in;
   logic rdv_ff, rdv_in;
   logic key_sel_ff, key_sel_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [spq_pkg::CNT_W-1:0] count_ff, count_in;
   logic [spq_pkg::IDX_W-1:0] rd_addr_ff, rd_addr_in;

   logic                      rd_en;
   logic                      proc;
   logic                      id_hit;
   logic                      wr_en;
   logic [spq_pkg::IDX_W-1:0] wr_addr;
   spq_pkg::entry_type        wr_data;
   logic [spq_pkg::KEY_W-1:0] d_key;
   logic [spq_pkg::KEY_W-1:0] n_key;
   spq_pkg::entry_type        req_entry;

   assign req_entry = '{prio: req_tdata[31:24], exec: req_tdata[23:8], id: req_tdata[7:0]};
   assign rd_en  = cmd.walk && !stop_ff && !ovf_ff && (rd_idx_ff < count_ff);
   assign proc   = rdv_ff && !stop_ff;
   assign id_hit = (rd_data_ff.id == new_ff.id);
   assign d_key  = spq_pkg::key_of(rd_data_ff, key_sel_ff);
   assign n_key  = spq_pkg::key_of(new_ff, key_sel_ff);

   assign status.walk_done = !rdv_ff && (stop_ff || ovf_ff || (rd_idx_ff >= count_ff));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = rd_addr_ff;
      wr_data    = carry_ff;
      carry_in   = carry_ff;
      placing_in = placing_ff;
      found_in   = found_ff;
      stop_in    = stop_ff;
      count_in   = count_ff;
      if (cmd.finish) begin
         if (mode_ff == spq_pkg::MODE_INSERT && !ovf_ff) begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[spq_pkg::IDX_W-1:0];
            wr_data  = carry_ff;
            count_in = count_ff + spq_pkg::CNT_W'(1);
         end else if (mode_ff == spq_pkg::MODE_REMOVE && removed_valid_ff) begin
            count_in = count_ff - spq_pkg::CNT_W'(1);
         end
      end else if (proc) begin
         case (mode_ff)
            spq_pkg::MODE_INSERT: begin
               if (placing_ff || (d_key > n_key)) begin
                  wr_en      = 1'b1;
                  wr_data    = carry_ff;
                  carry_in   = rd_data_ff;
                  placing_in = 1'b1;
               end
            end
            spq_pkg::MODE_REMOVE: begin
               wr_en   = 1'b1;
               wr_addr = rd_addr_ff - spq_pkg::IDX_W'(1);
               wr_data = rd_data_ff;
            end
            spq_pkg::MODE_UPDATE: begin
               if (id_hit) begin
                  wr_en    = 1'b1;
                  wr_data  = '{prio: rd_data_ff.prio, exec: new_ff.exec, id: rd_data_ff.id};
                  found_in = 1'b1;
                  stop_in  = 1'b1;
               end
            end
            spq_pkg::MODE_QUERY: begin
               if (id_hit) begin
                  found_in = 1'b1;
                  stop_in  = 1'b1;
               end
            end
            default: begin
               stop_in = 1'b1;
            end
         endcase
      end
      front_in = (wr_en && wr_addr == '0) ? wr_data : front_ff;
   end

   always_comb begin
      mode_in          = mode_ff;
      new_in           = new_ff;
      ovf_in           = ovf_ff;
      removed_in       = removed_ff;
      removed_valid_in = removed_valid_ff;
      rd_idx_in        = rd_idx_ff;
      rd_addr_in       = rd_addr_ff;
      rdv_in           = rd_en;
      if (cmd.start) begin
         mode_in          = spq_pkg::mode_type'(req_tuser);
         new_in           = req_entry;
         ovf_in           = (req_tuser == spq_pkg::MODE_INSERT) &&
                            (count_ff == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
         removed_in       = front_ff;
         removed_valid_in = (req_tuser == spq_pkg::MODE_REMOVE) && (count_ff != '0);
         rd_idx_in        = (req_tuser == spq_pkg::MODE_REMOVE) ? spq_pkg::CNT_W'(1) : '0;
      end else if (rd_en) begin
         rd_idx_in  = rd_idx_ff + spq_pkg::CNT_W'(1);
         rd_addr_in = rd_idx_ff[spq_pkg::IDX_W-1:0];
      end
   end

   always_comb begin
      rsp_in               = rsp_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_tready;
      key_sel_in           = csr_wen ? csr_wdata : key_sel_ff;
      if (cmd.finish) begin
         rsp_valid_in          = 1'b1;
         rsp_in.removed_valid  = removed_valid_ff;
         rsp_in.removed_id     = removed_valid_ff ? removed_ff.id : '0;
         rsp_in.removed_exec   = removed_valid_ff ? removed_ff.exec : '0;
         rsp_in.removed_prio   = removed_valid_ff ? removed_ff.prio : '0;
         rsp_in.found          = found_ff;
         rsp_in.queue_empty    = (count_in == '0);
         rsp_in.front_id       = (count_in == '0) ? '0 : front_in.id;
         rsp_in.front_exec     = (count_in == '0) ? '0 : front_in.exec;
         rsp_in.front_prio     = (count_in == '0) ? '0 : front_in.prio;
         rsp_in.entry_count    = spq_pkg::ENTRY_CNT_W'(count_in);
         rsp_in.overflow       = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx_ff[spq_pkg::IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         key_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         stop_ff      <= 1'b0;
      end else begin
         count_ff     <= count_in;
         key_sel_ff   <= key_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= rdv_in;
         stop_ff      <= cmd.start ? 1'b0 : stop_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff          <= mode_in;
      new_ff           <= new_in;
      carry_ff         <= cmd.start ? req_entry : carry_in;
      placing_ff       <= cmd.start ? 1'b0 : placing_in;
      found_ff         <= cmd.start ? 1'b0 : found_in;
      ovf_ff           <= ovf_in;
      removed_ff       <= removed_in;
      removed_valid_ff <= removed_valid_in;
      rd_idx_ff        <= rd_idx_in;
      rd_addr_ff       <= rd_addr_in;
      front_ff         <= front_in;
      rsp_ff           <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

[sv/sorted_priority_queue.sv]
// Top level of the sorted priority queue: sequencer, datapath and stream ports.
//
//   channel   direction  handshake              payload
//   req       in         req_tvalid/req_tready  tuser mode; tdata id, exec, prio
//   rsp       out        rsp_tvalid/rsp_tready  tdata result fields
//   csr       in         csr_wen                csr_wdata order_by_priority
//
// An item is accepted only once the previous one has finished. The walk reads one store
// entry per cycle through the single read port into a read data register. Reset clears
// the entry count, the key select and the result valid.
// A new item is accepted while a result waits; its finish stalls until rsp is free.
module sorted_priority_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [spq_pkg::REQ_TUSER_W-1:0]    req_tuser,  // mode[1:0]
   input  logic [spq_pkg::REQ_TDATA_W-1:0]    req_tdata,  // process_id, exec_time, prio
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // removed_valid, removed_id, removed_exec, removed_prio, found, front_id,
   // front_exec, front_prio, queue_empty, entry_count, overflow, zero pad
   output logic [spq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_wen,
   input  logic                               csr_wdata
);

   spq_pkg::cmd_type    cmd;
   spq_pkg::status_type status;
   spq_pkg::result_type rsp_result;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   spq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {(spq_pkg::RSP_TDATA_W - spq_pkg::RESULT_W)'(0), rsp_result};

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted during a walk");

   a_pop_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_result.removed_valid && rsp_result.overflow))
      else $error("pop and overflow in one result");

   a_found_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_result.found |-> !rsp_result.queue_empty)
      else $error("id found in an empty queue");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (spq_pkg::QUEUE_DEPTH < 32) |->
         (rsp_result.queue_empty == (rsp_result.entry_count == '0)))
      else $error("empty flag disagrees with count");

endmodule

[sim/tb.sv]
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 2 * spq_pkg::QUEUE_DEPTH + 8;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 165;
   localparam int DIRECTED_N   = 25;

   typedef struct {
      spq_pkg::mode_type   mode;
      logic [7:0]          id;
      logic [15:0]         ex;
      logic [7:0]          pr;
      bit                  fixed;
      spq_pkg::result_type want;
   } step_row_type;

   localparam spq_pkg::result_type R_EMPTY   = '{queue_empty: 1'b1, default: '0};
   localparam spq_pkg::result_type R_ONE_MAX = '{front_id: 8'hFF, front_exec: 16'hFFFF,
                                                 front_prio: 8'hFF, entry_count: 5'd1,
                                                 default: '0};
   localparam spq_pkg::result_type R_TWO_MIN = '{entry_count: 5'd2, default: '0};
   localparam spq_pkg::result_type R_NONE    = '0;

   step_row_type directed_steps [0:DIRECTED_N-1] = '{
      '{spq_pkg::MODE_REMOVE, 8'h00, 16'h0000, 8'h00, 1'b1, R_EMPTY},
      '{spq_pkg::MODE_QUERY,  8'h00, 16'h0000, 8'h00, 1'b1, R_EMPTY},
      '{spq_pkg::MODE_UPDATE, 8'h05, 16'h1234, 8'h00, 1'b1, R_EMPTY},
      '{spq_pkg::MODE_INSERT, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, R_ONE_MAX},
      '{spq_pkg::MODE_INSERT, 8'h00, 16'h0000, 8'h00, 1'b1, R_TWO_MIN},
      '{spq_pkg::MODE_INSERT, 8'h01, 16'h0000, 8'h07, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h02, 16'h8000, 8'h80, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h02, 16'h8000, 8'h01, 1'b0, R_NONE},
      '{spq_pkg::MODE_QUERY,  8'h02, 16'h0000, 8'h00, 1'b0, R_NONE},
      '{spq_pkg::MODE_UPDATE, 8'h02, 16'h0001, 8'h00, 1'b0, R_NONE},
      '{spq_pkg::MODE_QUERY,  8'h77, 16'h0000, 8'h00, 1'b0, R_NONE},
      '{spq_pkg::MODE_REMOVE, 8'h00, 16'h0000, 8'h00, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h10, 16'hA5A5, 8'hAA, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h11, 16'h5A5A, 8'h55, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h12, 16'h0100, 8'h10, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h13, 16'h7FFF, 8'hFE, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h14, 16'h0100, 8'h10, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h15, 16'hFFFE, 8'h7F, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h16, 16'h0002, 8'h00, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h17, 16'h3333, 8'hCC, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h18, 16'hCCCC, 8'h33, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h19, 16'h0F0F, 8'hF0, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h1A, 16'hF0F0, 8'h0F, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h1B, 16'h0000, 8'hFF, 1'b0, R_NONE},
      '{spq_pkg::MODE_INSERT, 8'h3C, 16'h0001, 8'h01, 1'b0, R_NONE}
   };

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [spq_pkg::REQ_TUSER_W-1:0] req_tuser;
   logic [spq_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [spq_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            csr_wen;
   logic                            csr_wdata;

   // expected result override for directed rows, travels with the item
   bit                  drive_fixed;
   spq_pkg::result_type drive_want;
   bit                  hold_request;

   spq_pkg::entry_type  shadow_entries[$];
   logic                shadow_by_prio;
   spq_pkg::result_type pending_results[$];

   int errors;
   int items_accepted;
   int results_checked;
   int mode_hits [4];
   int overflow_hits;
   int found_hits;
   int empty_pops;

   sorted_priority_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Run timed out with %0d results outstanding", pending_results.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [15:0] sort_key(input spq_pkg::entry_type x);
      return shadow_by_prio ? {8'h00, x.prio} : x.exec;
   endfunction

   function automatic spq_pkg::result_type predict_queue_step(
      input spq_pkg::mode_type m, input logic [7:0] id,
      input logic [15:0] ex, input logic [7:0] pr);
      spq_pkg::result_type r;
      spq_pkg::entry_type  e;
      int                  at;
      int                  hit;
      r = '0;
      e = '{prio: pr, exec: ex, id: id};
      case (m)
         spq_pkg::MODE_INSERT: begin
            if (shadow_entries.size() >= spq_pkg::QUEUE_DEPTH) begin
               r.overflow = 1'b1;
            end else begin
               at = shadow_entries.size();
               for (int i = 0; i < shadow_entries.size(); i++) begin
                  if (sort_key(shadow_entries[i]) > sort_key(e)) begin
                     at = i;
                     break;
                  end
               end
               shadow_entries.insert(at, e);
            end
         end
         spq_pkg::MODE_REMOVE: begin
            if (shadow_entries.size() > 0) begin
               e = shadow_entries.pop_front();
               r.removed_valid = 1'b1;
               r.removed_id    = e.id;
               r.removed_exec  = e.exec;
               r.removed_prio  = e.prio;
            end
         end
         default: begin
            hit = -1;
            for (int i = 0; i < shadow_entries.size(); i++) begin
               if (shadow_entries[i].id == id) begin
                  hit = i;
                  break;
               end
            end
            if (hit >= 0) begin
               r.found = 1'b1;
               if (m == spq_pkg::MODE_UPDATE) begin
                  e = shadow_entries[hit];
                  e.exec = ex;
                  shadow_entries[hit] = e;
               end
            end
         end
      endcase
      if (shadow_entries.size() > 0) begin
         r.front_id   = shadow_entries[0].id;
         r.front_exec = shadow_entries[0].exec;
         r.front_prio = shadow_entries[0].prio;
      end else begin
         r.queue_empty = 1'b1;
      end
      r.entry_count = spq_pkg::ENTRY_CNT_W'(shadow_entries.size());
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      spq_pkg::result_type got;
      spq_pkg::result_type want;
      spq_pkg::result_type calc;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = spq_pkg::result_type'(rsp_tdata[spq_pkg::RESULT_W-1:0]);
            check_field("pad", '0, 32'(rsp_tdata[spq_pkg::RSP_TDATA_W-1:spq_pkg::RESULT_W]));
            if (pending_results.size() == 0) begin
               $error("result arrived with nothing expected");
               errors++;
            end else begin
               want = pending_results.pop_front();
               check_field("removed_valid", 32'(want.removed_valid), 32'(got.removed_valid));
               check_field("removed_id",    32'(want.removed_id),    32'(got.removed_id));
               check_field("removed_exec",  32'(want.removed_exec),  32'(got.removed_exec));
               check_field("removed_prio",  32'(want.removed_prio),  32'(got.removed_prio));
               check_field("found",         32'(want.found),         32'(got.found));
               check_field("front_id",      32'(want.front_id),      32'(got.front_id));
               check_field("front_exec",    32'(want.front_exec),    32'(got.front_exec));
               check_field("front_prio",    32'(want.front_prio),    32'(got.front_prio));
               check_field("queue_empty",   32'(want.queue_empty),   32'(got.queue_empty));
               check_field("entry_count",   32'(want.entry_count),   32'(got.entry_count));
               check_field("overflow",      32'(want.overflow),      32'(got.overflow));
            end
            results_checked++;
         end
         if (req_tvalid && req_tready) begin
            calc = predict_queue_step(spq_pkg::mode_type'(req_tuser), req_tdata[7:0],
                                      req_tdata[23:8], req_tdata[31:24]);
            pending_results.push_back(drive_fixed ? drive_want : calc);
            items_accepted++;
            mode_hits[req_tuser]++;
            overflow_hits += int'(calc.overflow);
            found_hits    += int'(calc.found);
            if (spq_pkg::mode_type'(req_tuser) == spq_pkg::MODE_REMOVE && !calc.removed_valid)
               empty_pops++;
         end
      end
   end

   // receiver: stall patterns of varying span, plus one long hold-off on request
   initial begin
      int pattern;
      int span;
      int tick;
      rsp_tready = 1'b0;
      tick = 0;
      forever begin
         pattern = $urandom_range(0, 3);
         span    = $urandom_range(20, 120);
         repeat (span) begin
            @(negedge clock);
            tick++;
            if (hold_request) begin
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_request = 1'b0;
            end else begin
               case (pattern)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  2:       rsp_tready <= (tick % 4 == 0);
                  default: rsp_tready <= ($urandom_range(0, 7) != 0);
               endcase
            end
         end
      end
   end

   task automatic send_item(input spq_pkg::mode_type m, input logic [7:0] id,
                            input logic [15:0] ex, input logic [7:0] pr, input bit fixed,
                            input spq_pkg::result_type want);
      req_tvalid  <= 1'b1;
      req_tuser   <= m;
      req_tdata   <= {pr, ex, id};
      drive_fixed <= fixed;
      drive_want  <= want;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_results;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_order(input logic by_prio);
      csr_wen   <= 1'b1;
      csr_wdata <= by_prio;
      @(negedge clock);
      csr_wen <= 1'b0;
      shadow_by_prio = by_prio;
   endtask

   task automatic pick_item(input int fill_bias, output spq_pkg::mode_type m,
                            output logic [7:0] id, output logic [15:0] ex,
                            output logic [7:0] pr);
      int r;
      r  = $urandom_range(0, 99);
      ex = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 15)) : 16'($urandom);
      pr = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      id = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      if (r < fill_bias)
         m = spq_pkg::MODE_INSERT;
      else if (r < fill_bias + (100 - fill_bias) / 2)
         m = spq_pkg::MODE_REMOVE;
      else
         m = r[0] ? spq_pkg::MODE_UPDATE : spq_pkg::MODE_QUERY;
      if ((m == spq_pkg::MODE_UPDATE || m == spq_pkg::MODE_QUERY) && shadow_entries.size() > 0
          && $urandom_range(0, 3) != 0)
         id = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)].id;
   endtask

   initial begin
      int                fill_bias [PHASES];
      logic              order_plan [PHASES];
      int                burst;
      int                gap;
      spq_pkg::mode_type m;
      logic [7:0]        id;
      logic [15:0]       ex;
      logic [7:0]        pr;

      fill_bias    = '{70, 40, 55, 30, 65, 50};
      order_plan   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = '0;
      req_tdata    = '0;
      csr_wen      = 1'b0;
      csr_wdata    = 1'b0;
      drive_fixed  = 1'b0;
      drive_want   = '0;
      hold_request = 1'b0;
      shadow_by_prio = 1'b0;
      errors = 0;
      items_accepted = 0;
      results_checked = 0;
      overflow_hits = 0;
      found_hits = 0;
      empty_pops = 0;
      mode_hits = '{0, 0, 0, 0};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_order(1'b0);

      foreach (directed_steps[i])
         send_item(directed_steps[i].mode, directed_steps[i].id, directed_steps[i].ex,
                   directed_steps[i].pr, directed_steps[i].fixed, directed_steps[i].want);
      wait_results();

      for (int p = 0; p < PHASES; p++) begin
         write_order(order_plan[p]);
         burst = $urandom_range(1, 12);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 1 && k == 40)
               hold_request = 1'b1;
            if (p == 2 && k == 80)
               wait_results();
            pick_item(fill_bias[p], m, id, ex, pr);
            send_item(m, id, ex, pr, 1'b0, R_NONE);
            burst--;
            if (burst == 0) begin
               gap = $urandom_range(0, 6);
               if (gap > 0)
                  idle_sender(gap);
               burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
            end
         end
         wait_results();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         errors++;
      end
      $display("Covered %0d items, %0d results: %0d insert, %0d remove, %0d update, %0d query",
               items_accepted, results_checked, mode_hits[0], mode_hits[1], mode_hits[2],
               mode_hits[3]);
      $display("Dropped inserts on full: %0d, pops on empty: %0d, id hits: %0d, errors: %0d",
               overflow_hits, empty_pops, found_hits, errors);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
